/* hw/rtl/rxc_pkg.sv */
// Package: widths, coefficients, gamma tables and helper functions of the colour converter.
`default_nettype none

package rxc_pkg;

	// Fixed-point formats
	localparam int XYZ_FRAC_BITS    = 14;
	localparam int GAMMA_INDEX_BITS = 12;

	localparam int RGB_W   = 8;
	localparam int XYZ_W   = 15;
	localparam int LIN_W   = 17;               // linear value 0..65536 (Q1.16)
	localparam int OPND_W  = LIN_W;            // multiplier operand, holds LIN_W or XYZ_W
	localparam int COEF_W  = 19;               // signed Q16 matrix coefficient
	localparam int PROD_W  = COEF_W + OPND_W + 1;
	localparam int ACC_W   = PROD_W + 2;       // sum of three products
	localparam int GAM_W   = GAMMA_INDEX_BITS;
	localparam int ENC_W   = RGB_W;

	localparam int RND_SHIFT = 32 - XYZ_FRAC_BITS;
	localparam int ONE_SHIFT = 16 + XYZ_FRAC_BITS;
	localparam int K_SHIFT   = ONE_SHIFT - GAMMA_INDEX_BITS;

	localparam int ENC_STEPS  = 2;             // search steps per encode stage
	localparam int ENC_STAGES = ENC_W / ENC_STEPS;

	localparam int WIDE_W = 256;               // elaboration-time exact arithmetic

	localparam logic [XYZ_W-1:0]  XYZ_MAX   = '1;
	localparam logic [GAM_W-1:0]  K_MAX     = '1;
	localparam logic [ACC_W-1:0]  RND_HALF  = ACC_W'(1) << (RND_SHIFT - 1);

	// sRGB to XYZ and XYZ to sRGB matrices, Q16
	localparam logic signed [COEF_W-1:0] FWD_M [3][3] = '{
		'{COEF_W'(27031), COEF_W'(23434), COEF_W'(11825)},
		'{COEF_W'(13938), COEF_W'(46868), COEF_W'(4730)},
		'{COEF_W'(1267),  COEF_W'(7811),  COEF_W'(62279)}
	};

	localparam logic signed [COEF_W-1:0] INV_M [3][3] = '{
		'{COEF_W'(212366), COEF_W'(-100738), COEF_W'(-32672)},
		'{COEF_W'(-63522), COEF_W'(122946),  COEF_W'(2723)},
		'{COEF_W'(3647),   COEF_W'(-13371),  COEF_W'(69286)}
	};

	typedef logic [255:0][LIN_W-1:0] lin_tab_t;
	typedef logic [255:0][GAM_W-1:0] thr_tab_t;

	typedef struct packed {
		logic [RGB_W-1:0] red;
		logic [RGB_W-1:0] green;
		logic [RGB_W-1:0] blue;
		logic [XYZ_W-1:0] x;
		logic [XYZ_W-1:0] y;
		logic [XYZ_W-1:0] z;
	} pix_t;

	typedef struct packed {
		logic                  dir;
		logic [2:0][ACC_W-1:0] acc;
	} acc_item_t;

	typedef struct packed {
		logic                  dir;
		logic [2:0][XYZ_W-1:0] xyz;
		logic [2:0][GAM_W-1:0] k;
		logic [2:0][ENC_W-1:0] rgb;
	} enc_item_t;

	function automatic logic [WIDE_W-1:0] wide_pow(logic [WIDE_W-1:0] base, int unsigned e);
		logic [WIDE_W-1:0] acc;
		acc = WIDE_W'(1);
		for (int unsigned n = 0; n < e; n++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// lin(i) = round(65536 * (i/255)^2.2), halves up, found by exact search
	function automatic lin_tab_t lin_table();
		lin_tab_t          tab;
		logic [WIDE_W-1:0] k255;
		logic [WIDE_W-1:0] k2p17;
		logic [WIDE_W-1:0] rhs;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		k255  = wide_pow(WIDE_W'(255), 11);
		k2p17 = wide_pow(WIDE_W'(131072), 5);
		for (int unsigned i = 0; i < 256; i++) begin
			lo  = 0;
			hi  = 65536;
			rhs = wide_pow(WIDE_W'(i), 11) * k2p17;
			for (int unsigned n = 0; n < LIN_W + 1; n++) begin
				if (lo < hi) begin
					mid = lo + ((hi - lo + 1) >> 1);
					if (wide_pow(WIDE_W'(2 * mid - 1), 5) * k255 <= rhs)
						lo = mid;
					else
						hi = mid - 1;
				end
			end
			tab[i] = LIN_W'(lo);
		end
		return tab;
	endfunction

	// thr[c]: smallest index k with ((2c-1)/510)^2.2 <= k/D; thr[0] is 0
	function automatic thr_tab_t thr_table();
		thr_tab_t          tab;
		logic [WIDE_W-1:0] k510;
		logic [WIDE_W-1:0] lhs;
		int unsigned       d;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		d    = (1 << GAMMA_INDEX_BITS) - 1;
		k510 = wide_pow(WIDE_W'(510), 11);
		tab[0] = '0;
		for (int unsigned c = 1; c < 256; c++) begin
			lhs = wide_pow(WIDE_W'(2 * c - 1), 11) * wide_pow(WIDE_W'(d), 5);
			lo  = 0;
			hi  = d;
			for (int unsigned n = 0; n < GAM_W + 1; n++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (lhs <= wide_pow(WIDE_W'(mid), 5) * k510)
						hi = mid;
					else
						lo = mid + 1;
				end
			end
			tab[c] = GAM_W'(lo);
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TAB = lin_table();
	localparam thr_tab_t THR_TAB = thr_table();

	// One greedy step of the encode search: try setting bit pos
	function automatic logic [ENC_W-1:0] enc_step(logic [ENC_W-1:0] c, logic [GAM_W-1:0] k,
			int unsigned pos);
		logic [ENC_W-1:0] cand;
		cand = c | (ENC_W'(1) << pos);
		return (THR_TAB[cand] <= k) ? cand : c;
	endfunction

	// All steps of one encode stage, three channels side by side
	function automatic enc_item_t enc_pass(enc_item_t it, int unsigned stg);
		enc_item_t        res;
		logic [ENC_W-1:0] c;
		res = it;
		for (int unsigned i = 0; i < 3; i++) begin
			c = it.rgb[i];
			for (int unsigned t = 0; t < ENC_STEPS; t++) begin
				c = enc_step(c, it.k[i], ENC_W - 1 - stg * ENC_STEPS - t);
			end
			res.rgb[i] = c;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/rxc_if.sv */
// Interfaces: pixel input channel and result output channel.
`default_nettype none

interface rxc_in_if import rxc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] red;
	logic [RGB_W-1:0] green;
	logic [RGB_W-1:0] blue;
	logic [XYZ_W-1:0] x_in;
	logic [XYZ_W-1:0] y_in;
	logic [XYZ_W-1:0] z_in;

	modport source (output valid, red, green, blue, x_in, y_in, z_in, input ready);
	modport sink   (input valid, red, green, blue, x_in, y_in, z_in, output ready);
endinterface

interface rxc_out_if import rxc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [XYZ_W-1:0] x_out;
	logic [XYZ_W-1:0] y_out;
	logic [XYZ_W-1:0] z_out;
	logic [RGB_W-1:0] red_out;
	logic [RGB_W-1:0] green_out;
	logic [RGB_W-1:0] blue_out;

	modport source (output valid, x_out, y_out, z_out, red_out, green_out, blue_out,
		input ready);
	modport sink   (input valid, x_out, y_out, z_out, red_out, green_out, blue_out,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/rxc_mac.sv */
// Matrix stages: gamma linearisation or operand select, 3x3 multiply, row sums.
`default_nettype none

module rxc_mac import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dir,
	input  logic      in_valid,
	output logic      in_ready,
	input  pix_t      in_pix,
	output logic      out_valid,
	input  logic      out_ready,
	output acc_item_t out_item
);

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic                   dir_s1, dir_s2;
	logic [2:0][OPND_W-1:0] opnd_s1;
	logic [2:0][OPND_W-1:0] opnd_d;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic signed [PROD_W-1:0] prod_d  [3][3];
	logic signed [COEF_W-1:0] coef_c  [3][3];
	acc_item_t              item_s3;
	acc_item_t              item_d;

	logic [2:0][RGB_W-1:0]  rgb_c;
	logic [2:0][XYZ_W-1:0]  xyz_c;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign rgb_c = {in_pix.blue, in_pix.green, in_pix.red};
	assign xyz_c = {in_pix.z, in_pix.y, in_pix.x};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			opnd_d[j] = dir ? OPND_W'(xyz_c[j]) : LIN_TAB[rgb_c[j]];
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				coef_c[r][j] = dir_s1 ? INV_M[r][j] : FWD_M[r][j];
				prod_d[r][j] = coef_c[r][j] * $signed({1'b0, opnd_s1[j]});
			end
		end
	end

	always_comb begin
		item_d.dir = dir_s2;
		for (int r = 0; r < 3; r++) begin
			item_d.acc[r] = ACC_W'(prod_s2[r][0]) + ACC_W'(prod_s2[r][1])
				+ ACC_W'(prod_s2[r][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	// payload: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dir_s1  <= dir;
			opnd_s1 <= opnd_d;
		end
		if (rdy_s2 && vld_s1) begin
			dir_s2  <= dir_s1;
			prod_s2 <= prod_d;
		end
		if (rdy_s3 && vld_s2) begin
			item_s3 <= item_d;
		end
	end

	assign out_valid = vld_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

/* hw/rtl/rxc_post.sv */
// Scaling stage: round and saturate XYZ, or clamp and reduce to a gamma index.
`default_nettype none

module rxc_post import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  acc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output enc_item_t out_item
);

	logic      vld_s4;
	enc_item_t item_s4;
	enc_item_t item_d;

	logic [ACC_W-1:0] rnd_c [3];
	logic [ACC_W-1:0] q_c   [3];
	logic [ACC_W-1:0] t_c   [3];

	assign in_ready = !vld_s4 || out_ready;

	always_comb begin
		item_d     = '0;
		item_d.dir = in_item.dir;
		for (int r = 0; r < 3; r++) begin
			rnd_c[r] = in_item.acc[r] + RND_HALF;
			q_c[r]   = rnd_c[r] >> RND_SHIFT;
			t_c[r]   = in_item.acc[r] >> K_SHIFT;
			if (!in_item.dir) begin
				item_d.xyz[r] = (q_c[r] > ACC_W'(XYZ_MAX)) ? XYZ_MAX : q_c[r][XYZ_W-1:0];
			end else if (in_item.acc[r][ACC_W-1]) begin
				item_d.k[r] = '0;    // negative linear value: encode to black
			end else begin
				item_d.k[r] = (t_c[r] > ACC_W'(K_MAX)) ? K_MAX : t_c[r][GAM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_ready) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s4 <= item_d;
		end
	end

	assign out_valid = vld_s4;
	assign out_item  = item_s4;

endmodule

`default_nettype wire

/* hw/rtl/rxc_enc.sv */
// Gamma encode stages: pipelined greedy search of the threshold table, MSB first.
`default_nettype none

module rxc_enc import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  enc_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output enc_item_t out_item
);

	// index of item_s and vld_s is the encode stage
	enc_item_t               item_s [ENC_STAGES];
	logic [ENC_STAGES-1:0]   vld_s;
	enc_item_t               src_c  [ENC_STAGES];
	enc_item_t               nxt_c  [ENC_STAGES];
	logic [ENC_STAGES-1:0]   src_vld;
	logic [ENC_STAGES:0]     rdy;

	assign rdy[ENC_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	for (genvar s = 0; s < ENC_STAGES; s++) begin : g_stg
		if (s == 0) begin : g_first
			assign src_c[s]   = in_item;
			assign src_vld[s] = in_valid;
		end else begin : g_next
			assign src_c[s]   = item_s[s-1];
			assign src_vld[s] = vld_s[s-1];
		end

		assign rdy[s]   = !vld_s[s] || rdy[s+1];
		assign nxt_c[s] = enc_pass(src_c[s], s);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (rdy[s]) begin
				vld_s[s] <= src_vld[s];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[s] && src_vld[s]) begin
				item_s[s] <= nxt_c[s];
			end
		end
	end

	assign out_valid = vld_s[ENC_STAGES-1];
	assign out_item  = item_s[ENC_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/rgb_xyz_color_convert_top.sv */
// Top level: RGB / XYZ colour converter with direction register and pipeline.
`default_nettype none

// Pixel-rate colour converter between 8-bit gamma-encoded RGB (power 2.2 curve)
// and unsigned Q1.14 XYZ using the sRGB D65 matrices. The direction register
// selects the mode: 0 takes red/green/blue and gives x_out/y_out/z_out, 1 takes
// x_in/y_in/z_in and gives red_out/green_out/blue_out; the unused result fields
// read zero. Write the register only while no pixel is in flight. The pipeline
// takes one pixel transfer per clock while the output is not stalled and has
// eight register stages: three for table lookup, 3x3 multiply and row sum,
// one for rounding or clamping, and four for the gamma encode, which searches
// a 256-entry threshold table two bits per stage. Each stage has its own valid
// bit and holds under back-pressure; an empty stage accepts data even while the
// output stage waits, so bubbles close up. No state links pixels and there is
// no start-up sweep: the block takes pixels straight after reset.
module rgb_xyz_color_convert_top import rxc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	rxc_in_if.sink    pixel,
	rxc_out_if.source result
);

	logic dir_q;

	pix_t      pix_c;
	logic      mac_valid, mac_ready;
	acc_item_t mac_item;
	logic      post_valid, post_ready;
	enc_item_t post_item;
	enc_item_t enc_item;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	assign pix_c = '{
		red:   pixel.red,
		green: pixel.green,
		blue:  pixel.blue,
		x:     pixel.x_in,
		y:     pixel.y_in,
		z:     pixel.z_in
	};

	// stages 1..3: linearise, multiply, sum
	rxc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.dir       (dir_q),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.in_pix    (pix_c),
		.out_valid (mac_valid),
		.out_ready (mac_ready),
		.out_item  (mac_item)
	);

	// stage 4: round and saturate, or clamp to a gamma index
	rxc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mac_valid),
		.in_ready  (mac_ready),
		.in_item   (mac_item),
		.out_valid (post_valid),
		.out_ready (post_ready),
		.out_item  (post_item)
	);

	// stages 5..8: gamma encode; the last stage is the output register
	rxc_enc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (post_valid),
		.in_ready  (post_ready),
		.in_item   (post_item),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_item  (enc_item)
	);

	// reverse-mode results carry zero XYZ already; drop RGB in forward mode
	assign result.x_out     = enc_item.xyz[0];
	assign result.y_out     = enc_item.xyz[1];
	assign result.z_out     = enc_item.xyz[2];
	assign result.red_out   = enc_item.dir ? enc_item.rgb[0] : '0;
	assign result.green_out = enc_item.dir ? enc_item.rgb[1] : '0;
	assign result.blue_out  = enc_item.dir ? enc_item.rgb[2] : '0;

endmodule

`default_nettype wire

/* hw/rtl/rxc_checker.sv */
// Checker on the top-level ports of the colour converter, with its bind.
`default_nettype none

module rxc_checker import rxc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_we,
	input logic             cfg_wdata,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [XYZ_W-1:0] x_out,
	input logic [XYZ_W-1:0] y_out,
	input logic [XYZ_W-1:0] z_out,
	input logic [RGB_W-1:0] red_out,
	input logic [RGB_W-1:0] green_out,
	input logic [RGB_W-1:0] blue_out
);

	// shadow of the direction register
	logic dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(x_out) && $stable(y_out) && $stable(z_out)
			&& $stable(red_out) && $stable(green_out) && $stable(blue_out))
		else $error("result changed while stalled");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked with a free output stage");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (dir_q ? (x_out == '0 && y_out == '0 && z_out == '0)
			: (red_out == '0 && green_out == '0 && blue_out == '0)))
		else $error("unused result fields not zero");

endmodule

bind rgb_xyz_color_convert_top rxc_checker u_rxc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.x_out     (result.x_out),
	.y_out     (result.y_out),
	.z_out     (result.z_out),
	.red_out   (result.red_out),
	.green_out (result.green_out),
	.blue_out  (result.blue_out)
);

`default_nettype wire
